// ----- rtl/dss_pkg.sv -----
package dss_pkg;

  // input action codes
  localparam logic [2:0] ACT_PUSH_LO = 3'd0;
  localparam logic [2:0] ACT_PUSH_HI = 3'd1;
  localparam logic [2:0] ACT_POP_LO  = 3'd2;
  localparam logic [2:0] ACT_POP_HI  = 3'd3;
  localparam logic [2:0] ACT_DUMP_LO = 3'd4;
  localparam logic [2:0] ACT_DUMP_HI = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // stack selector
  localparam logic SIDE_LO = 1'b0;
  localparam logic SIDE_HI = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2
  } op_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t                op;
    logic               side;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

endpackage

// ----- rtl/dss_front.sv -----
module dss_front
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_take
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       push;
  logic       pop;
  cmd_t       dec_cmd;

  assign in_stall = (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = fifo_r[rd_ptr_r];

  // classify the incoming word; unused codes are dropped
  always_comb begin
    dec_cmd.value = in_value;
    dec_cmd.side  = in_action[0];
    case (in_action)
      ACT_PUSH_LO, ACT_PUSH_HI: dec_cmd.op = OP_PUSH;
      ACT_POP_LO,  ACT_POP_HI:  dec_cmd.op = OP_POP;
      default:                  dec_cmd.op = OP_DUMP;
    endcase
  end

  assign push = accept && (in_action inside {[ACT_PUSH_LO:ACT_DUMP_HI]});
  assign pop  = q_take && q_valid;

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

// ----- rtl/dss_back.sv -----
module dss_back
  import dss_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_take,
  output logic [CW-1:0]      low_cnt,
  output logic [CW-1:0]      high_cnt,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      low_cnt_r, low_cnt_nxt;
  logic [CW-1:0]      high_cnt_r, high_cnt_nxt;
  logic [CW-1:0]      remain_r, remain_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic               side_r, side_nxt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_data_r;
  logic               out_last_r;

  logic               out_free;
  logic               emit;
  logic [1:0]         emit_status;
  logic signed [31:0] emit_data;
  logic               emit_last;

  logic               we;
  logic [AW-1:0]      waddr;
  logic               re;
  logic [AW-1:0]      raddr;

  logic [CW:0]        used;
  logic               full;
  logic               side_empty;
  logic [CW-1:0]      side_cnt;
  logic [AW-1:0]      top_addr;

  assign out_free = !out_valid_r || !out_stall;
  assign used     = {1'b0, low_cnt_r} + {1'b0, high_cnt_r};
  assign full     = (used >= (CW+1)'(DEPTH));
  assign side_cnt = (q_cmd.side == SIDE_HI) ? high_cnt_r : low_cnt_r;
  assign side_empty = (side_cnt == '0);

  // address of the top entry of the selected stack
  assign top_addr = (q_cmd.side == SIDE_HI) ? AW'(CW'(DEPTH) - high_cnt_r)
                                            : AW'(low_cnt_r - CW'(1));

  // command execution
  always_comb begin
    state_nxt    = state_r;
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    remain_nxt   = remain_r;
    ptr_nxt      = ptr_r;
    side_nxt     = side_r;
    q_take       = 1'b0;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_data    = '0;
    emit_last    = 1'b1;
    we           = 1'b0;
    waddr        = low_cnt_r[AW-1:0];
    re           = 1'b0;
    raddr        = top_addr;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_PUSH: begin
              if (out_free) begin
                q_take = 1'b1;
                emit   = 1'b1;
                if (full) begin
                  emit_status = ST_OVERFLOW;
                end else begin
                  we = 1'b1;
                  if (q_cmd.side == SIDE_HI) begin
                    waddr        = AW'(CW'(DEPTH - 1) - high_cnt_r);
                    high_cnt_nxt = high_cnt_r + CW'(1);
                  end else begin
                    low_cnt_nxt = low_cnt_r + CW'(1);
                  end
                end
              end
            end
            OP_POP, OP_DUMP: begin
              if (side_empty) begin
                if (out_free) begin
                  q_take      = 1'b1;
                  emit        = 1'b1;
                  emit_status = (q_cmd.op == OP_POP) ? ST_UNDERFLOW : ST_EMPTY;
                end
              end else begin
                // read the top entry, result goes out from the emit state
                q_take    = 1'b1;
                re        = 1'b1;
                side_nxt  = q_cmd.side;
                state_nxt = S_EMIT;
                if (q_cmd.op == OP_POP) begin
                  remain_nxt = CW'(1);
                  if (q_cmd.side == SIDE_HI) begin
                    high_cnt_nxt = high_cnt_r - CW'(1);
                  end else begin
                    low_cnt_nxt = low_cnt_r - CW'(1);
                  end
                end else begin
                  remain_nxt = side_cnt;
                  ptr_nxt    = (q_cmd.side == SIDE_HI) ? top_addr + AW'(1)
                                                       : top_addr - AW'(1);
                end
              end
            end
            default: begin
              q_take = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        // one stored word per cycle while the output is not stalled; next read overlaps the output handoff
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rd_data_r;
          emit_last = (remain_r == CW'(1));
          if (remain_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            re         = 1'b1;
            raddr      = ptr_r;
            remain_nxt = remain_r - CW'(1);
            ptr_nxt    = (side_r == SIDE_HI) ? ptr_r + AW'(1) : ptr_r - AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      low_cnt_r  <= '0;
      high_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      low_cnt_r  <= low_cnt_nxt;
      high_cnt_r <= high_cnt_nxt;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    ptr_r    <= ptr_nxt;
    side_r   <= side_nxt;
  end

  // shared stack memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= q_cmd.value;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_data_r   <= emit_data;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;
  assign low_cnt    = low_cnt_r;
  assign high_cnt   = high_cnt_r;

endmodule

// ----- rtl/dual_stack_shared_memory_top.sv -----
// Push and empty-stack results pass through the command queue and the output register;
// pop and dump data also pass through the registered memory read.
// A pop or dump holds the back end in its emit state while stored words come through
// the single read port of the shared memory; the 2-entry queue absorbs input meanwhile.
// Reset (rst_n, synchronous): clears both stack counts, the queue and the output valid;
// memory contents are not cleared and are read only after being written.
module dual_stack_shared_memory_top
  import dss_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          q_valid;
  cmd_t          q_cmd;
  logic          q_take;
  logic [CW-1:0] low_cnt;
  logic [CW-1:0] high_cnt;

  // accept and classify
  dss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_value  (in_value),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take)
  );

  // execute against the shared memory
  dss_back #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_take     (q_take),
    .low_cnt    (low_cnt),
    .high_cnt   (high_cnt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  // the two stacks together never exceed the memory
  a_no_overcommit: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, low_cnt} + {1'b0, high_cnt}) <= (CW+1)'(DEPTH))
    else $error("stack counts exceed depth");

  // back side only takes a queued command that exists
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("command taken from empty queue");

  // a low push that fits moves the low count by one and leaves the high count
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_take && q_cmd.op == OP_PUSH && q_cmd.side == SIDE_LO
      && ({1'b0, low_cnt} + {1'b0, high_cnt}) < (CW+1)'(DEPTH)
    |=> low_cnt == $past(low_cnt) + CW'(1) && $stable(high_cnt))
    else $error("low push did not advance count");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
  import dss_pkg::*;
;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 180;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  // action codes the block must ignore
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               is_last;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_action = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_data;
  logic               out_last;

  dual_stack_shared_memory_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_status(out_status),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  cmd_word_t          cmd_queue[$];
  outcome_t           stack_outcomes[$];
  logic signed [31:0] shadow_mem [DEPTH];
  int                 lo_fill = 0;
  int                 hi_fill = 0;
  int                 err_count = 0;
  int                 cycle_count = 0;
  bit                 word_taken = 1'b0;
  int                 in_gap = 0;
  int                 out_gap = 0;
  bit                 in_calm = 1'b0;
  bit                 out_calm = 1'b0;
  cmd_word_t          next_cmd;
  outcome_t           want;

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // gap lengths: mostly none or short, a few long; none at all while calm
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // data values biased toward the extremes
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cmd(logic [2:0] action, logic signed [31:0] value);
    cmd_word_t c;
    c.action = action;
    c.value  = value;
    cmd_queue.push_back(c);
  endfunction

  function automatic void push_outcome(logic [1:0] status, logic signed [31:0] data,
                                       logic is_last);
    outcome_t o;
    o.status  = status;
    o.data    = data;
    o.is_last = is_last;
    stack_outcomes.push_back(o);
  endfunction

  // shadow of the two stacks: update state and queue the results of one word
  function automatic void apply_stack_action(logic [2:0] action, logic signed [31:0] value);
    bit full;
    full = (lo_fill + hi_fill) >= DEPTH;
    case (action)
      ACT_PUSH_LO: begin
        if (full) begin
          push_outcome(ST_OVERFLOW, '0, 1'b1);
        end else begin
          shadow_mem[lo_fill] = value;
          lo_fill++;
          push_outcome(ST_OK, '0, 1'b1);
        end
      end
      ACT_PUSH_HI: begin
        if (full) begin
          push_outcome(ST_OVERFLOW, '0, 1'b1);
        end else begin
          hi_fill++;
          shadow_mem[DEPTH - hi_fill] = value;
          push_outcome(ST_OK, '0, 1'b1);
        end
      end
      ACT_POP_LO: begin
        if (lo_fill == 0) begin
          push_outcome(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          lo_fill--;
          push_outcome(ST_OK, shadow_mem[lo_fill], 1'b1);
        end
      end
      ACT_POP_HI: begin
        if (hi_fill == 0) begin
          push_outcome(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          push_outcome(ST_OK, shadow_mem[DEPTH - hi_fill], 1'b1);
          hi_fill--;
        end
      end
      ACT_DUMP_LO: begin
        if (lo_fill == 0) begin
          push_outcome(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = lo_fill; i > 0; i--) push_outcome(ST_OK, shadow_mem[i - 1], i == 1);
        end
      end
      ACT_DUMP_HI: begin
        if (hi_fill == 0) begin
          push_outcome(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = DEPTH - hi_fill; i < DEPTH; i++) begin
            push_outcome(ST_OK, shadow_mem[i], i == DEPTH - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // input driver: new word only when the previous one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        next_cmd = cmd_queue.pop_front();
        in_valid  <= 1'b1;
        in_action <= next_cmd.action;
        in_value  <= next_cmd.value;
        in_gap = pick_gap(in_calm);
        if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) out_gap = pick_gap(out_calm);
      if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
    end
  end

  // monitor: check results first, then record the accepted input word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (stack_outcomes.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT) begin
            $display("unexpected result: status %0d data %0d last %0b",
                     out_status, out_data, out_last);
          end
        end else begin
          want = stack_outcomes.pop_front();
          if (out_status !== want.status || out_data !== want.data ||
              out_last !== want.is_last) begin
            err_count++;
            if (err_count <= REPORT_LIMIT) begin
              $display("mismatch: status exp %0d got %0d, data exp %0d got %0d, last exp %0b got %0b",
                       want.status, out_status, want.data, out_data, want.is_last, out_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_stack_action(in_action, in_value);
        word_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int  n_random;
    bit  filled;
    int  pick;
    int  burst;

    // empty stacks: underflow and empty dumps
    queue_cmd(ACT_POP_LO, rand_value());
    queue_cmd(ACT_POP_HI, rand_value());
    queue_cmd(ACT_DUMP_LO, rand_value());
    queue_cmd(ACT_DUMP_HI, rand_value());
    // extreme values on both stacks
    queue_cmd(ACT_PUSH_LO, 32'h7fff_ffff);
    queue_cmd(ACT_PUSH_LO, 32'h8000_0000);
    queue_cmd(ACT_PUSH_HI, 32'h0000_0000);
    queue_cmd(ACT_PUSH_HI, 32'hffff_ffff);
    queue_cmd(ACT_PUSH_HI, 32'h8000_0000);
    queue_cmd(ACT_DUMP_LO, 32'hffff_ffff);
    queue_cmd(ACT_DUMP_HI, 32'h0000_0000);
    // unused codes leave everything alone
    queue_cmd(ACT_SPARE_6, 32'hffff_ffff);
    queue_cmd(ACT_SPARE_7, 32'h8000_0000);
    // drain both stacks past empty
    queue_cmd(ACT_POP_LO, rand_value());
    queue_cmd(ACT_POP_LO, rand_value());
    queue_cmd(ACT_POP_LO, rand_value());
    queue_cmd(ACT_POP_HI, rand_value());
    queue_cmd(ACT_POP_HI, rand_value());
    queue_cmd(ACT_POP_HI, rand_value());
    queue_cmd(ACT_POP_HI, rand_value());

    n_random = 0;
    filled = 1'b0;
    while (n_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (!filled && n_random >= 40) begin
        // fill the shared memory past full, dump both sides at full size, back off
        for (int k = 0; k < DEPTH + 2; k++) begin
          queue_cmd($urandom_range(0, 1) ? ACT_PUSH_HI : ACT_PUSH_LO, rand_value());
        end
        queue_cmd(ACT_DUMP_LO, rand_value());
        queue_cmd(ACT_DUMP_HI, rand_value());
        for (int k = 0; k < 20; k++) begin
          queue_cmd($urandom_range(0, 1) ? ACT_POP_HI : ACT_POP_LO, rand_value());
        end
        n_random += DEPTH + 24;
        filled = 1'b1;
      end else if (pick < 8) begin
        // a short run of pushes, then a look at one stack
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst; k++) begin
          queue_cmd($urandom_range(0, 1) ? ACT_PUSH_HI : ACT_PUSH_LO, rand_value());
        end
        queue_cmd(3'($urandom_range(2, 5)), rand_value());
        n_random += burst + 1;
      end else if (pick < 19) begin
        queue_cmd(3'($urandom_range(0, 5)), rand_value());
        n_random++;
      end else begin
        queue_cmd($urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6, rand_value());
      end
    end

    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
    while (stack_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
